### hw/rtl/fqd_pkg.sv
// Shared constants for the filtered quadrature decoder: configuration register map and output width.
package fqd_pkg;

	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_DECAY     = 2'd0;
	localparam cfg_idx_t REG_WEIGHT    = 2'd1;
	localparam cfg_idx_t REG_HIGH_THR  = 2'd2;
	localparam cfg_idx_t REG_LOW_THR   = 2'd3;

	localparam int OUT_W = 32;

endpackage

### hw/rtl/filtered_quadrature_decoder_top.sv
// Filtered quadrature decoder top level: pin filters, hysteresis, counter and index capture.
// One beat of raw A, B and index samples is taken per clock with no gaps while in_stall is low;
// its result beat is registered through the input register, then the result register that holds
// the filter multiply, saturating add, threshold compare and counter step. A stalled result
// holds one more beat in the input register before in_stall rises. Configuration writes are
// taken in any cycle (cfg_ready is tied high) and are meant to happen while no beat is in
// flight. Levels reset to half scale, filtered bits and the counters to zero.
module filtered_quadrature_decoder_top #(
	parameter int COUNT_WIDTH = 32,
	parameter int LEVEL_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   pin_a,
	input  logic                   pin_b,
	input  logic                   pin_index,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [fqd_pkg::OUT_W-1:0] position,
	output logic signed [fqd_pkg::OUT_W-1:0] index_position,
	output logic                   chan_a,
	output logic                   chan_b,
	output logic                   chan_index,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  fqd_pkg::cfg_idx_t      cfg_index,
	input  logic [LEVEL_WIDTH-1:0] cfg_data
);
	import fqd_pkg::*;

	localparam int LW = LEVEL_WIDTH;
	localparam int CW = COUNT_WIDTH;

	localparam logic [LW-1:0] DECAY_RST  = LW'((64'd58982 << LW) >> 16);
	localparam logic [LW-1:0] WEIGHT_RST = LW'((64'd6554 << LW) >> 16);
	localparam logic [LW-1:0] HIGH_RST   = LW'((64'd42598 << LW) >> 16);
	localparam logic [LW-1:0] LOW_RST    = LW'((64'd22938 << LW) >> 16);
	localparam logic [LW-1:0] LEVEL_RST  = LW'(1) << (LW - 1);
	localparam logic [LW-1:0] LEVEL_MAX  = {LW{1'b1}};

	logic [LW-1:0] decay_q, weight_q, high_q, low_q;
	logic [LW-1:0] level_a_q, level_b_q, level_idx_q;
	logic          bit_a_q, bit_b_q, bit_idx_q;
	logic [CW-1:0] count_q, captured_q;

	logic vld_s1;
	logic pin_a_s1, pin_b_s1, pin_idx_s1;
	logic out_valid_q;
	logic adv;

	logic [LW-1:0] level_a_nx, level_b_nx, level_idx_nx;
	logic          bit_a_nx, bit_b_nx, bit_idx_nx;
	logic [2:0]    delta;
	logic [CW-1:0] count_nx;

	function automatic logic [LW-1:0] filt(input logic [LW-1:0] level, input logic pin,
			input logic [LW-1:0] decay, input logic [LW-1:0] weight);
		logic [2*LW-1:0] prod;
		logic [LW:0]     sum;
		prod = {{LW{1'b0}}, level} * {{LW{1'b0}}, decay};
		sum  = {1'b0, prod[2*LW-1:LW]} + (pin ? {1'b0, weight} : {(LW+1){1'b0}});
		return sum[LW] ? LEVEL_MAX : sum[LW-1:0];
	endfunction

	function automatic logic hyst(input logic [LW-1:0] level, input logic b,
			input logic [LW-1:0] hi, input logic [LW-1:0] lo);
		logic r;
		r = b;
		if (level < lo) r = 1'b0;
		if (level > hi) r = 1'b1;
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign adv       = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = vld_s1 && !adv;
	assign out_valid = out_valid_q;

	always_comb begin
		level_a_nx   = filt(level_a_q, pin_a_s1, decay_q, weight_q);
		level_b_nx   = filt(level_b_q, pin_b_s1, decay_q, weight_q);
		level_idx_nx = filt(level_idx_q, pin_idx_s1, decay_q, weight_q);
		// B decides on its old level, A and index on the new one
		bit_b_nx     = hyst(level_b_q, bit_b_q, high_q, low_q);
		bit_a_nx     = hyst(level_a_nx, bit_a_q, high_q, low_q);
		bit_idx_nx   = hyst(level_idx_nx, bit_idx_q, high_q, low_q);
		delta = 3'sd0;
		if (bit_a_nx != bit_a_q)
			delta = (bit_a_nx != bit_b_nx) ? 3'sd1 : -3'sd1;
		if (bit_b_nx != bit_b_q)
			delta = delta + ((bit_a_nx != bit_b_nx) ? -3'sd1 : 3'sd1);
		count_nx = count_q + {{(CW-3){delta[2]}}, delta};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q  <= DECAY_RST;
			weight_q <= WEIGHT_RST;
			high_q   <= HIGH_RST;
			low_q    <= LOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DECAY:    decay_q  <= cfg_data;
				REG_WEIGHT:   weight_q <= cfg_data;
				REG_HIGH_THR: high_q   <= cfg_data;
				REG_LOW_THR:  low_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_a_s1   <= pin_a;
			pin_b_s1   <= pin_b;
			pin_idx_s1 <= pin_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_a_q   <= LEVEL_RST;
			level_b_q   <= LEVEL_RST;
			level_idx_q <= LEVEL_RST;
			bit_a_q     <= 1'b0;
			bit_b_q     <= 1'b0;
			bit_idx_q   <= 1'b0;
			count_q     <= '0;
			captured_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				level_a_q   <= level_a_nx;
				level_b_q   <= level_b_nx;
				level_idx_q <= level_idx_nx;
				bit_a_q     <= bit_a_nx;
				bit_b_q     <= bit_b_nx;
				bit_idx_q   <= bit_idx_nx;
				count_q     <= count_nx;
				if (bit_idx_nx)
					captured_q <= count_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat is the state itself: it only moves on adv, which needs the beat taken
	generate
		if (CW >= OUT_W) begin : g_out_trunc
			assign position       = count_q[OUT_W-1:0];
			assign index_position = captured_q[OUT_W-1:0];
		end else begin : g_out_ext
			assign position       = {{(OUT_W-CW){1'b0}}, count_q};
			assign index_position = {{(OUT_W-CW){1'b0}}, captured_q};
		end
	endgenerate

	assign chan_a     = bit_a_q;
	assign chan_b     = bit_b_q;
	assign chan_index = bit_idx_q;

endmodule

### hw/rtl/fqd_checker.sv
// Port-level checker for the filtered quadrature decoder, bound to the top level.
module fqd_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [fqd_pkg::OUT_W-1:0] position,
	input logic [fqd_pkg::OUT_W-1:0] index_position,
	input logic                   chan_a,
	input logic                   chan_b,
	input logic                   chan_index
);
	import fqd_pkg::*;

	logic [OUT_W-1:0] last_pos_q;
	logic             last_a_q, last_b_q;
	logic [7:0]       step;

	assign step = position[7:0] - last_pos_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			last_a_q   <= 1'b0;
			last_b_q   <= 1'b0;
		end else if (out_valid && !out_stall) begin
			last_pos_q <= position;
			last_a_q   <= chan_a;
			last_b_q   <= chan_b;
		end
	end

	default disable iff (!arst_n);

	a_hold: assert property (@(posedge clk) out_valid && out_stall |=>
			out_valid && $stable(position) && $stable(index_position))
		else $error("stalled result beat changed");

	a_index_capture: assert property (@(posedge clk) out_valid && chan_index |->
			index_position == position)
		else $error("index position not captured while index high");

	a_step_range: assert property (@(posedge clk) out_valid |->
			step == 8'd0 || step == 8'd1 || step == 8'd2 || step == 8'hFF || step == 8'hFE)
		else $error("position moved more than two counts in one beat");

	a_no_edge_no_step: assert property (@(posedge clk)
			out_valid && chan_a == last_a_q && chan_b == last_b_q |-> step == 8'd0)
		else $error("position moved without a channel edge");

	a_stall_cause: assert property (@(posedge clk) in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

endmodule

bind filtered_quadrature_decoder_top fqd_checker u_fqd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.position       (position),
	.index_position (index_position),
	.chan_a         (chan_a),
	.chan_b         (chan_b),
	.chan_index     (chan_index)
);

### tb/filtered_quadrature_decoder_top_test.sv
// Self-checking testbench for the filtered quadrature decoder top level.
module filtered_quadrature_decoder_top_test;
	import fqd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [15:0] DECAY_RST  = 16'd58982;
	localparam logic [15:0] WEIGHT_RST = 16'd6554;
	localparam logic [15:0] HIGH_RST   = 16'd42598;
	localparam logic [15:0] LOW_RST    = 16'd22938;

	typedef struct packed {
		logic a;
		logic b;
		logic idx;
	} pin_sample_t;

	typedef struct {
		logic signed [OUT_W-1:0] position;
		logic signed [OUT_W-1:0] index_position;
		logic chan_a;
		logic chan_b;
		logic chan_index;
	} decoder_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic pin_a = 1'b0;
	logic pin_b = 1'b0;
	logic pin_index = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] position;
	logic signed [OUT_W-1:0] index_position;
	logic chan_a;
	logic chan_b;
	logic chan_index;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = REG_DECAY;
	logic [15:0] cfg_data = 16'd0;

	filtered_quadrature_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_a(pin_a),
		.pin_b(pin_b),
		.pin_index(pin_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position(position),
		.index_position(index_position),
		.chan_a(chan_a),
		.chan_b(chan_b),
		.chan_index(chan_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// decoder shadow state
	logic [15:0] decay_reg = DECAY_RST;
	logic [15:0] weight_reg = WEIGHT_RST;
	logic [15:0] high_reg = HIGH_RST;
	logic [15:0] low_reg = LOW_RST;
	logic [15:0] lvl_a = 16'h8000;
	logic [15:0] lvl_b = 16'h8000;
	logic [15:0] lvl_idx = 16'h8000;
	logic bit_a = 1'b0;
	logic bit_b = 1'b0;
	logic bit_idx = 1'b0;
	logic last_a = 1'b0;
	logic last_b = 1'b0;
	logic [31:0] count = 32'd0;
	logic [31:0] captured = 32'd0;

	pin_sample_t pending_pins[$];
	decoder_result_t expected_counts[$];
	int mismatches = 0;
	int cycles = 0;
	logic in_taken = 1'b0;
	int hold_asks = 0;

	function automatic logic [15:0] lowpass(logic [15:0] lvl, logic pin);
		logic [31:0] prod;
		logic [16:0] sum;
		prod = 32'(lvl) * 32'(decay_reg);
		sum = {1'b0, prod[31:16]} + (pin ? {1'b0, weight_reg} : 17'd0);
		return sum[16] ? 16'hFFFF : sum[15:0];
	endfunction

	function automatic logic hysteresis(logic [15:0] lvl, logic cur);
		logic nxt;
		nxt = cur;
		if (lvl < low_reg)
			nxt = 1'b0;
		if (lvl > high_reg)
			nxt = 1'b1;
		return nxt;
	endfunction

	task automatic decode_tick(pin_sample_t s);
		decoder_result_t r;
		lvl_a = lowpass(lvl_a, s.a);
		bit_b = hysteresis(lvl_b, bit_b);
		lvl_b = lowpass(lvl_b, s.b);
		bit_a = hysteresis(lvl_a, bit_a);
		if (bit_a != last_a)
			count = (bit_a != bit_b) ? count + 32'd1 : count - 32'd1;
		if (bit_b != last_b)
			count = (bit_a != bit_b) ? count - 32'd1 : count + 32'd1;
		last_a = bit_a;
		last_b = bit_b;
		lvl_idx = lowpass(lvl_idx, s.idx);
		bit_idx = hysteresis(lvl_idx, bit_idx);
		if (bit_idx)
			captured = count;
		r.position = count;
		r.index_position = captured;
		r.chan_a = bit_a;
		r.chan_b = bit_b;
		r.chan_index = bit_idx;
		expected_counts.push_back(r);
	endtask

	// input acceptance and prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			decode_tick('{a: pin_a, b: pin_b, idx: pin_index});
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// sender: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		pin_sample_t s;
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_pins.size() > 0) begin
				s = pending_pins.pop_front();
				in_valid <= 1'b1;
				pin_a <= s.a;
				pin_b <= s.b;
				pin_index <= s.idx;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
						: $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	int hold_served = 0;
	always @(negedge clk) begin
		if (hold_left == 0 && hold_served < hold_asks) begin
			hold_served++;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 256);
			end
			mode_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		decoder_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: position %0d index %0d", position,
						index_position);
			end else begin
				e = expected_counts.pop_front();
				if (position !== e.position || index_position !== e.index_position ||
						chan_a !== e.chan_a || chan_b !== e.chan_b ||
						chan_index !== e.chan_index) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp pos %0d idx %0d a%b b%b i%b, got pos %0d idx %0d a%b b%b i%b",
							e.position, e.index_position, e.chan_a, e.chan_b,
							e.chan_index, position, index_position, chan_a, chan_b,
							chan_index);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DECAY: decay_reg = data;
			REG_WEIGHT: weight_reg = data;
			REG_HIGH_THR: high_reg = data;
			REG_LOW_THR: low_reg = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_filter(logic [15:0] d, logic [15:0] w, logic [15:0] h, logic [15:0] l);
		write_reg(REG_DECAY, d);
		write_reg(REG_WEIGHT, w);
		write_reg(REG_HIGH_THR, h);
		write_reg(REG_LOW_THR, l);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pins(logic a, logic b, logic idx);
		pending_pins.push_back('{a: a, b: b, idx: idx});
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending_pins.size() > 0 || in_valid ||
			expected_counts.size() > 0);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly gray-code walks with random dwell, some glitches, some noise
	task automatic push_motion(int n);
		int pushed;
		int steps;
		int dwell;
		int dir;
		logic [1:0] phase;
		logic idx_on;
		pin_sample_t s;
		pushed = 0;
		phase = 2'd0;
		dir = 1;
		while (pushed < n) begin
			if ($urandom_range(0, 9) < 8) begin
				steps = $urandom_range(4, 20);
				idx_on = $urandom_range(0, 1);
				repeat (steps) begin
					if ($urandom_range(0, 4) == 0)
						dir = -dir;
					phase = phase + 2'(dir);
					dwell = $urandom_range(1, 14);
					repeat (dwell) begin
						if (pushed < n) begin
							s.a = phase[0] ^ phase[1];
							s.b = phase[1];
							s.idx = idx_on && phase == 2'd0;
							if ($urandom_range(0, 9) == 0)
								s = s ^ 3'(1 << $urandom_range(0, 2));
							pending_pins.push_back(s);
							pushed++;
						end
					end
				end
			end else begin
				repeat ($urandom_range(5, 30)) begin
					if (pushed < n) begin
						pending_pins.push_back(3'($urandom_range(0, 7)));
						pushed++;
					end
				end
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset filter settings
		push_motion(150);
		hold_asks++;
		wait_idle();

		// filter transparent: A follows its pin, B lags one beat
		set_filter(16'h0000, 16'hFFFF, 16'h7FFF, 16'h7FFF);
		push_pins(0, 0, 0);
		push_pins(1, 0, 0);
		push_pins(1, 1, 1);
		push_pins(0, 1, 0);
		push_pins(0, 0, 0);
		push_pins(0, 0, 0);
		push_pins(0, 1, 1);
		push_pins(1, 1, 0);
		push_pins(1, 0, 0);
		push_pins(0, 0, 0);
		push_pins(0, 1, 0);
		push_pins(1, 1, 1); // A and B flip on the same beat
		push_pins(0, 0, 0);
		push_pins(1, 1, 0);
		wait_idle();

		// saturation with thresholds at the rails: bits hold
		set_filter(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		push_pins(1, 1, 1);
		push_pins(1, 1, 1);
		push_pins(0, 0, 0);
		push_pins(1, 0, 1);
		wait_idle();

		// low above high: both tests met, high wins
		set_filter(16'h8000, 16'h4000, 16'h0000, 16'hFFFF);
		push_pins(1, 1, 1);
		push_pins(0, 0, 0);
		push_pins(1, 0, 1);
		wait_idle();
		set_filter(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		push_pins(1, 1, 1);
		push_pins(0, 1, 0);
		wait_idle();

		repeat (6) begin
			if ($urandom_range(0, 3) == 0)
				set_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				set_filter(16'($urandom_range(0, 16'hF000)),
					16'($urandom_range(16'h1000, 16'hFFFF)),
					16'($urandom_range(16'h8000, 16'hE000)),
					16'($urandom_range(16'h1000, 16'h7FFF)));
			push_motion(150);
			hold_asks++;
			wait_idle();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
hw/rtl/fqd_pkg.sv
hw/rtl/filtered_quadrature_decoder_top.sv
hw/rtl/fqd_checker.sv
tb/filtered_quadrature_decoder_top_test.sv
